// ----- rtl/smp2srgb_pkg.sv -----
// Shared types, constants and the sRGB code threshold table.
`timescale 1ns / 1ps

package smp2srgb_pkg;

  localparam int unsigned CodeW          = 8;
  localparam int unsigned NumCodes       = 256;
  localparam int unsigned KeyW           = 31;
  localparam int unsigned LastLinearCode = 10;
  localparam int unsigned PowDenom       = 269025;
  localparam int unsigned LinScale       = 32946;
  localparam logic [31:0] OnePattern     = 32'h3F80_0000;
  localparam logic [KeyW-1:0] InfPattern = 31'h7F80_0000;

  typedef enum logic [1:0] {
    SampleUint   = 2'd0,
    SampleHalf   = 2'd1,
    SampleSingle = 2'd2
  } sample_type_e;

  // One item in flight through the threshold search.
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [CodeW-1:0] code;
  } srch_t;

  typedef logic [NumCodes-1:0][31:0] thr_tab_t;

  // True when the positive single with bit pattern pat encodes to at least code.
  // Exact integer comparison, evaluated only while the table is built.
  function automatic logic reaches_code(input logic [31:0] pat, input int unsigned code);
    logic [511:0] lhs;
    logic [511:0] rhs;
    logic [511:0] mant;
    int unsigned  ex;
    int unsigned  sh;
    int unsigned  num;
    ex = {24'd0, pat[30:23]};
    if (ex == 0) return 1'b0;
    if (pat >= OnePattern) return 1'b1;
    mant = {488'd0, 1'b1, pat[22:0]};
    sh = 150 - ex;
    if (code <= LastLinearCode) begin
      if (ex < 100) return 1'b0;
      lhs = mant * 512'(LinScale);
      rhs = 512'(10 * code) << sh;
    end else begin
      if (ex < 118) return 1'b0;
      num = 1000 * code + 14025;
      lhs = mant;
      for (int i = 0; i < 4; i++) lhs = lhs * mant;
      rhs = 512'd1;
      for (int i = 0; i < 12; i++) begin
        lhs = lhs * 512'(PowDenom);
        rhs = rhs * 512'(num);
      end
      rhs = rhs << (5 * sh);
    end
    return (lhs >= rhs);
  endfunction

  // Entry k is the smallest single pattern that encodes to k or more.
  function automatic thr_tab_t build_thr();
    thr_tab_t    tab;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    tab = '0;
    for (int unsigned code = 1; code < NumCodes; code++) begin
      lo = '0;
      hi = OnePattern;
      for (int it = 0; it < 32; it++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (reaches_code(mid, code)) hi = mid;
          else lo = mid + 32'd1;
        end
      end
      tab[CodeW'(code)] = lo;
    end
    return tab;
  endfunction

  localparam thr_tab_t SrgbThr = build_thr();

endpackage

// ----- rtl/smp2srgb_search.sv -----
// Pipelined binary search of a linear key against the sRGB threshold table.
`timescale 1ns / 1ps

module smp2srgb_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  smp2srgb_pkg::srch_t  stage_i,
  output smp2srgb_pkg::srch_t  stage_o
);
  import smp2srgb_pkg::*;

  localparam int unsigned NumSteps = CodeW;

  srch_t            chain [NumSteps+1];
  srch_t            st_d  [NumSteps];
  logic             vld_q [NumSteps];
  logic [KeyW-1:0]  key_q [NumSteps];
  logic [CodeW-1:0] code_q[NumSteps];

  assign chain[0] = stage_i;

  // Each stage decides one code bit, most significant first.
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    localparam logic [CodeW-1:0] TryBit  = CodeW'(1) << (NumSteps - 1 - i);
    localparam logic [CodeW-1:0] LowMask = TryBit - CodeW'(1);
    logic [CodeW-1:0] cand;

    assign cand = chain[i].code | TryBit;

    always_comb begin
      st_d[i] = chain[i];
      if (32'(chain[i].key) >= SrgbThr[cand]) begin
        st_d[i].code = cand;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= st_d[i].valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        key_q[i]  <= st_d[i].key;
        code_q[i] <= st_d[i].code;
      end
    end

    assign chain[i+1] = '{valid: vld_q[i], key: key_q[i], code: code_q[i]};

    // Bits not yet decided must still be clear.
    a_low_bits_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[i] |-> ((code_q[i] & LowMask) == '0))
      else $error("search stage holds undecided code bits");
  end

  assign stage_o = chain[NumSteps];

  a_final_reached : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_o.valid |-> (32'(stage_o.key) >= SrgbThr[stage_o.code]))
    else $error("result code lies above the key");

  a_final_tight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_o.valid && (stage_o.code != '1)) |->
      (32'(stage_o.key) < SrgbThr[CodeW'(stage_o.code + CodeW'(1))]))
    else $error("result code stops short of the key");

endmodule

// ----- rtl/channel_sample_to_srgb8.sv -----
// Top level: converts one raw channel sample to an sRGB-encoded byte.
`timescale 1ns / 1ps

// The block accepts one channel sample per clock while the output side does
// not stall, typed as an unsigned 32-bit integer, an IEEE half or an IEEE
// single, and returns floor(255 * f(v)) where f is the sRGB transfer curve. A
// transfer on the input side yields exactly one transfer on the output side,
// in order. The first register stage decodes the sample: a half is widened
// exactly to single precision, an integer becomes zero or one, and negative
// values and NaN are folded to zero. The remaining eight stages perform a
// binary search of the single-precision bit pattern against a constant table
// of 255 code thresholds, one table read and one 32-bit compare per stage,
// deciding one bit of the byte in each. The last search stage is the output
// register. The whole pipeline advances together, so a stall on the output
// holds every stage and the input ready drops only while a finished result
// waits to be taken. Type code three is handled as an unsigned integer, the
// upper half of a half sample is ignored, and +Inf saturates to 255.
module channel_sample_to_srgb8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_bits_i,
  input  logic [1:0]  sample_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  srgb_byte_o
);
  import smp2srgb_pkg::*;

  logic            adv;
  logic [4:0]      h_exp;
  logic [9:0]      h_man;
  logic [3:0]      lead;
  logic [3:0]      nshift;
  logic [9:0]      norm_man;
  logic [7:0]      sub_exp;
  logic [KeyW-1:0] half_pat;
  logic [KeyW-1:0] pat;
  logic            neg;
  logic            is_uint;
  logic [KeyW-1:0] key_d;
  logic            dec_vld_q;
  logic [KeyW-1:0] dec_key_q;
  srch_t           srch_in;
  srch_t           srch_out;

  // The whole pipeline moves when the output register is empty or drained.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Half to single widening. Subnormal halves are normalized by locating the
  // leading one of the mantissa.
  assign h_exp = sample_bits_i[14:10];
  assign h_man = sample_bits_i[9:0];

  always_comb begin
    lead = '0;
    for (int b = 0; b < 10; b++) begin
      if (h_man[b]) lead = 4'(b);
    end
  end

  assign nshift   = 4'd10 - lead;
  assign norm_man = h_man << nshift;
  assign sub_exp  = 8'd103 + 8'(lead);

  always_comb begin
    case (h_exp)
      5'h1F: half_pat = {8'hFF, h_man, 13'd0};
      5'h00: half_pat = (h_man == '0) ? '0 : {sub_exp, norm_man, 13'd0};
      default: half_pat = {8'(h_exp) + 8'd112, h_man, 13'd0};
    endcase
  end

  // Fold every type into a non-negative search key. Integers map to zero or
  // to the pattern of 1.0; negative values and NaN map to zero.
  always_comb begin
    neg     = 1'b0;
    pat     = '0;
    is_uint = 1'b0;
    case (sample_type_e'(sample_type_i))
      SampleHalf: begin
        neg = sample_bits_i[15];
        pat = half_pat;
      end
      SampleSingle: begin
        neg = sample_bits_i[31];
        pat = sample_bits_i[30:0];
      end
      default: begin
        is_uint = 1'b1;
      end
    endcase
    if (is_uint) begin
      key_d = (sample_bits_i != '0) ? OnePattern[KeyW-1:0] : '0;
    end else if (neg || (pat > InfPattern)) begin
      key_d = '0;
    end else begin
      key_d = pat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
    end else if (adv) begin
      dec_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_key_q <= key_d;
    end
  end

  assign srch_in = '{valid: dec_vld_q, key: dec_key_q, code: '0};

  smp2srgb_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .stage_i (srch_in),
    .stage_o (srch_out)
  );

  assign out_valid_o = srch_out.valid;
  assign srgb_byte_o = srch_out.code;

  a_key_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_vld_q |-> (dec_key_q <= InfPattern))
    else $error("decoded key above the infinity pattern");

  a_out_rise_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output became valid while the pipeline was held");

  a_out_fall_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output result dropped without a transfer");

endmodule

// ----- test/tb_channel_sample_to_srgb8.sv -----
// Self-checking testbench for the channel sample to sRGB byte converter.
`timescale 1ns / 1ps

// The testbench sends raw channel samples of every type code through the
// converter and compares each returned byte with a prediction made here.
//
// The predictor decodes the sample the same way the block must. A half is
// widened exactly to single precision. An integer is zero or saturating. A
// negative value or a NaN folds to zero. It then finds the sRGB code of a
// positive single below one by a binary search over the code itself: a code k
// is reached when floor(255 * f(v)) >= k. That test is done with exact wide
// integer arithmetic. In the linear segment it is v * 32946 >= 10 * k. In the
// power segment it is v^5 * 269025^12 >= (1000 * k + 14025)^12. The block
// searches a threshold table over the sample. The predictor searches over the
// code instead, so the two methods check each other.
//
// A short directed list covers the type codes, signed zero, NaN, infinity,
// subnormals, the upper half of a half sample, and values around the
// linear-to-power knee and just below one. Random samples then follow, mostly
// positive values inside the encoding range. Both sides of the pipeline idle
// at random, with calm stretches in which they do not idle at all.
module tb_channel_sample_to_srgb8;
  import smp2srgb_pkg::*;

  // Type code three is decoded as an unsigned integer. The package has no name
  // for it.
  localparam logic [1:0]  SampleAltUint = 2'd3;
  localparam logic [31:0] SingleOne     = 32'h3F80_0000;
  localparam logic [31:0] SingleInf     = 32'h7F80_0000;
  localparam int unsigned LinGain       = 32946;
  localparam int unsigned PowBase       = 269025;
  localparam int unsigned KneeCode      = 10;
  localparam int          RandItems     = 1500;
  localparam int          DrainCycles   = 30;
  localparam int          StuckLimit    = 500;

  // Marks whether a directed row carries its expected byte or leaves it to
  // the predictor.
  localparam logic Listed   = 1'b1;
  localparam logic Computed = 1'b0;

  typedef struct packed {
    logic [31:0] bits;
    logic [1:0]  kind;
    logic        typed;
    logic [7:0]  srgb;
  } vec_t;

  typedef struct {
    logic [31:0] bits;
    logic [1:0]  kind;
    logic [7:0]  srgb;
  } srgb_exp_t;

  localparam int NumDir = 26;
  localparam vec_t [0:NumDir-1] DirVec = {
    // Integer samples: zero gives 0, anything else saturates.
    {32'h0000_0000, SampleUint,    Listed,   8'd0},
    {32'h0000_0001, SampleUint,    Listed,   8'd255},
    {32'hFFFF_FFFF, SampleUint,    Listed,   8'd255},
    {32'h0000_0000, SampleAltUint, Listed,   8'd0},
    {32'h8000_0000, SampleAltUint, Listed,   8'd255},
    // Single samples: signed zero, one and above, NaN, negatives, subnormals.
    {32'h0000_0000, SampleSingle,  Listed,   8'd0},
    {32'h8000_0000, SampleSingle,  Listed,   8'd0},
    {32'h3F80_0000, SampleSingle,  Listed,   8'd255},
    {32'h7F7F_FFFF, SampleSingle,  Listed,   8'd255},
    {32'h7F80_0000, SampleSingle,  Listed,   8'd255},
    {32'h7FC0_0000, SampleSingle,  Listed,   8'd0},
    {32'h7F80_0001, SampleSingle,  Listed,   8'd0},
    {32'hFFC0_0000, SampleSingle,  Listed,   8'd0},
    {32'h0000_0001, SampleSingle,  Listed,   8'd0},
    {32'h007F_FFFF, SampleSingle,  Listed,   8'd0},
    // One half, just below one, near the knee, and the smallest normal.
    {32'h3F00_0000, SampleSingle,  Computed, 8'd0},
    {32'h3F7F_FFFF, SampleSingle,  Computed, 8'd0},
    {32'h3B4D_2E1C, SampleSingle,  Computed, 8'd0},
    {32'h0080_0000, SampleSingle,  Computed, 8'd0},
    // Half samples. Some rows carry garbage in the upper 16 bits that must be ignored.
    {32'hFFFF_3C00, SampleHalf,    Listed,   8'd255},
    {32'h0000_7C00, SampleHalf,    Listed,   8'd255},
    {32'h0000_7E00, SampleHalf,    Listed,   8'd0},
    {32'h0000_FC00, SampleHalf,    Listed,   8'd0},
    {32'h0000_8000, SampleHalf,    Listed,   8'd0},
    {32'h0000_0001, SampleHalf,    Computed, 8'd0},
    {32'hA5A5_3BFF, SampleHalf,    Computed, 8'd0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] sample_bits_i = '0;
  logic [1:0]  sample_type_i = SampleUint;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  srgb_byte_o;

  srgb_exp_t    srgb_fifo[$];
  int           mismatch_count = 0;
  int           sent_count     = 0;
  int           stuck_cycles   = 0;
  logic         calm_in        = 1'b0;
  logic         calm_out       = 1'b0;
  logic [511:0] base_pow12;

  channel_sample_to_srgb8 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_bits_i(sample_bits_i),
    .sample_type_i(sample_type_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .srgb_byte_o  (srgb_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The widening is exact. A subnormal half becomes a normal single after its
  // leading one is shifted up to the hidden bit position.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [10:0] frac;
    logic [7:0]  ex;
    frac = {1'b0, h[9:0]};
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    if (frac == 11'd0) return {h[15], 31'd0};
    ex = 8'd113;
    while (!frac[10]) begin
      frac = frac << 1;
      ex = ex - 8'd1;
    end
    return {h[15], ex, frac[9:0], 13'd0};
  endfunction

  // Is floor(255 * f(v)) >= k, for a positive single v below one? Each side
  // is scaled by 2^(150 - exponent), or by its fifth power in the power segment, so that both stay whole numbers.
  function automatic logic at_least_code(input logic [31:0] pat, input logic [7:0] k);
    logic [511:0] lhs;
    logic [511:0] rhs;
    logic [511:0] mant;
    int unsigned  ex;
    int unsigned  sh;
    int unsigned  num;
    ex = 32'(pat[30:23]);
    if (ex == 0) return 1'b0;
    mant = 512'({1'b1, pat[22:0]});
    sh = 150 - ex;
    if (k <= KneeCode) begin
      if (ex < 100) return 1'b0;
      lhs = mant * 512'(LinGain);
      rhs = 512'(10 * k) << sh;
    end else begin
      // Below 2^-9 the value is far under the first power-segment code.
      if (ex < 118) return 1'b0;
      num = 1000 * k + 14025;
      lhs = mant * mant * mant * mant * mant * base_pow12;
      rhs = 512'd1;
      for (int i = 0; i < 12; i++) rhs = rhs * 512'(num);
      rhs = rhs << (5 * sh);
    end
    return lhs >= rhs;
  endfunction

  function automatic logic [7:0] srgb_of_sample(input logic [31:0] bits,
                                                input logic [1:0] kind);
    logic [31:0] pat;
    logic [7:0]  code;
    logic [7:0]  trial;
    case (kind)
      SampleHalf:   pat = half_to_single(bits[15:0]);
      SampleSingle: pat = bits;
      default:      return (bits != 32'd0) ? 8'd255 : 8'd0;
    endcase
    // The sign bit set, and NaN, both give zero. One and above saturates.
    if (pat[31] || pat > SingleInf) return 8'd0;
    if (pat >= SingleOne) return 8'd255;
    // The test is monotone in k, so the code can be settled one bit at a
    // time, starting from the top bit.
    code = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      trial = code | (8'd1 << b);
      if (at_least_code(pat, trial)) code = trial;
    end
    return code;
  endfunction

  // Puts one sample on the input side and waits for its transfer. The valid
  // signal stays high across back-to-back items. It drops only when a gap is
  // drawn, and it rises again at a later edge.
  task automatic send_sample(input logic [31:0] bits, input logic [1:0] kind,
                             input logic typed, input logic [7:0] typed_srgb);
    int        gap;
    srgb_exp_t entry;
    if (sent_count % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_bits_i <= bits;
    sample_type_i <= kind;
    do @(posedge clk_i); while (!in_ready_o);
    entry.bits = bits;
    entry.kind = kind;
    entry.srgb = typed ? typed_srgb : srgb_of_sample(bits, kind);
    srgb_fifo.push_back(entry);
    sent_count++;
  endtask

  initial begin : stimulus
    vec_t        row;
    int          r;
    logic [31:0] bits;
    logic [1:0]  kind;
    logic [15:0] half;
    base_pow12 = 512'd1;
    for (int i = 0; i < 12; i++) base_pow12 = base_pow12 * 512'(PowBase);
    wait (rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      row = DirVec[i];
      send_sample(row.bits, row.kind, row.typed, row.srgb);
    end

    // Most random samples are positive values inside the encoding range,
    // with exponents spread over the linear and power segments. The rest are
    // raw bit patterns, which bring in negatives, NaN, infinities and
    // subnormals.
    for (int n = 0; n < RandItems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        kind = ($urandom_range(0, 1) == 0) ? SampleUint : SampleAltUint;
        bits = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
      end else if (r < 40) begin
        kind = SampleHalf;
        if ($urandom_range(0, 3) == 0) half = 16'($urandom);
        else half = {1'b0, 15'($urandom_range(0, 15'h3BFF))};
        bits = {16'($urandom), half};
      end else begin
        kind = SampleSingle;
        if ($urandom_range(0, 4) == 0) bits = 32'($urandom);
        else bits = {1'b0, 8'($urandom_range(96, 126)), 23'($urandom)};
      end
      send_sample(bits, kind, Computed, 8'd0);
    end
    in_valid_i <= 1'b0;

    // The watchdog still guards this wait if a result never comes.
    while (srgb_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The output side draws a stall before each result it takes. Calm
  // stretches keep it ready throughout, so the pipeline also runs at full
  // rate.
  initial begin : result_side
    int stall;
    int taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = calm_out ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Every output transfer is checked against the oldest sample still in
  // flight.
  always @(posedge clk_i) begin : result_check
    srgb_exp_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (srgb_fifo.size() == 0) begin
        $display("%0t: unexpected result %0d with no sample in flight", $time, srgb_byte_o);
        mismatch_count++;
      end else begin
        head = srgb_fifo.pop_front();
        if (srgb_byte_o !== head.srgb) begin
          $display("%0t: sample %h type %0d: expected %0d, actual %0d",
                   $time, head.bits, head.kind, head.srgb, srgb_byte_o);
          mismatch_count++;
        end
      end
    end
  end

  // Ends a hung run. Any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
